/* hdl/rsc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_pkg
// Types and constants shared by the read span cutter modules.
// ----------------------------------------------------------------------------
package rsc_pkg;

   localparam int POS_BITS  = 20;
   localparam int MAX_SPANS = 4096;
   localparam int CNT_BITS  = $clog2(MAX_SPANS + 1);
   localparam int CFG_BITS  = 20;
   localparam int IDX_BITS  = 2;
   localparam int REQ_BYTES = (POS_BITS + 7) / 8;
   localparam int RSP_FIELD_BITS = 3 * POS_BITS + 4 * CNT_BITS + 2 * POS_BITS;
   localparam int RSP_BYTES = (RSP_FIELD_BITS + 7) / 8;

   localparam logic [POS_BITS-1:0] POS_MAX    = '1;
   localparam logic [CNT_BITS-1:0] SPAN_LIMIT = CNT_BITS'(MAX_SPANS);

   typedef enum logic [IDX_BITS-1:0] {
      REG_CUT_SHIFT   = 2'd0,
      REG_REMNANT_LEN = 2'd1,
      REG_KEEP_MIN    = 2'd2,
      REG_UNUSED      = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      OUT_KEPT    = 2'd0,
      OUT_DROPPED = 2'd1,
      OUT_EMPTY   = 2'd2,
      OUT_NONE    = 2'd3
   } outcome_type;

   typedef struct packed {
      logic [5:0]          cut_shift;
      logic [5:0]          remnant_len;
      logic [POS_BITS-1:0] keep_min;
   } cfg_type;

   typedef struct packed {
      logic                is_end;
      logic [POS_BITS-1:0] position;
   } item_type;

   typedef struct packed {
      outcome_type         outcome;
      logic [POS_BITS-1:0] seg_start;
      logic [POS_BITS-1:0] seg_end;
      logic [POS_BITS-1:0] untrimmed_start;
      logic [CNT_BITS-1:0] span_number;
      logic                read_done;
      logic [CNT_BITS-1:0] spans_in_read;
      logic [CNT_BITS-1:0] kept_total;
      logic [CNT_BITS-1:0] dropped_total;
      logic [POS_BITS-1:0] dropped_bases;
      logic [POS_BITS-1:0] trimmed_bases;
   } result_type;

endpackage : rsc_pkg
`default_nettype wire

/* hdl/rsc_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_cfg_regs
// Configuration registers written through the csr port.
// ----------------------------------------------------------------------------
module rsc_cfg_regs (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_wen,
   input  wire  [rsc_pkg::IDX_BITS-1:0] csr_index,
   input  wire  [rsc_pkg::CFG_BITS-1:0] csr_wdata,
   output rsc_pkg::cfg_type             cfg
);
   import rsc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   reg_index_type idx;

   assign idx = reg_index_type'(csr_index);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (idx)
            REG_CUT_SHIFT:   cfg_in.cut_shift   = csr_wdata[5:0];
            REG_REMNANT_LEN: cfg_in.remnant_len = csr_wdata[5:0];
            REG_KEEP_MIN:    cfg_in.keep_min    = csr_wdata[POS_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule : rsc_cfg_regs
`default_nettype wire

/* hdl/rsc_in_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_in_stage
// Input register; holds one item until the result stage can take it.
// ----------------------------------------------------------------------------
module rsc_in_stage (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_ready,
   input  rsc_pkg::item_type   in_item,
   input  wire                 down_ready,
   output logic                stage_valid,
   output logic                advance,
   output rsc_pkg::item_type   stage_item
);
   import rsc_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   assign advance  = valid_ff && down_ready;
   assign in_ready = !valid_ff || down_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      valid_in = take ? 1'b1 : (advance ? 1'b0 : valid_ff);
      item_in  = take ? in_item : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !down_ready |=> valid_ff && $stable(item_ff))
      else $error("held item lost or changed");

endmodule : rsc_in_stage
`default_nettype wire

/* hdl/rsc_span_eval.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_span_eval
// Per-read state and span arithmetic; state updates as each item advances.
// ----------------------------------------------------------------------------
module rsc_span_eval (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 advance,
   input  rsc_pkg::item_type   item,
   input  rsc_pkg::cfg_type    cfg,
   output rsc_pkg::result_type result
);
   import rsc_pkg::*;

   logic [POS_BITS-1:0] last_cut_ff, last_cut_in;
   logic [CNT_BITS-1:0] span_count_ff, span_count_in;
   logic [CNT_BITS-1:0] kept_count_ff, kept_count_in;
   logic [CNT_BITS-1:0] drop_count_ff, drop_count_in;
   logic [POS_BITS-1:0] drop_sum_ff, drop_sum_in;
   logic [POS_BITS-1:0] trim_sum_ff, trim_sum_in;

   logic [POS_BITS:0]   cut_sum;
   logic [POS_BITS-1:0] seg_from;
   logic [POS_BITS-1:0] seg_to;
   logic [POS_BITS:0]   trim_raw;
   logic [POS_BITS-1:0] tstart;
   logic [POS_BITS-1:0] trim_len;
   logic [POS_BITS:0]   trim_acc;
   logic [POS_BITS-1:0] span_len;
   logic [POS_BITS:0]   drop_acc;
   logic [CNT_BITS-1:0] span_next, kept_next, drop_next;
   logic [POS_BITS-1:0] drop_sum_next, trim_sum_next;
   logic                empty, kept;
   outcome_type         outcome;

   always_comb begin
      seg_from = last_cut_ff;
      cut_sum  = {1'b0, item.position} + (POS_BITS+1)'(cfg.cut_shift);
      if (item.is_end) begin
         seg_to = item.position;
      end else begin
         seg_to = cut_sum[POS_BITS] ? POS_MAX : cut_sum[POS_BITS-1:0];
      end

      trim_raw = {1'b0, seg_from} + (POS_BITS+1)'(cfg.remnant_len);
      if (span_count_ff == '0) begin
         tstart = seg_from;
      end else if (trim_raw > {1'b0, seg_to}) begin
         tstart = (seg_to < seg_from) ? seg_from : seg_to;
      end else begin
         tstart = trim_raw[POS_BITS-1:0];
      end
      trim_len = tstart - seg_from;
      trim_acc = {1'b0, trim_sum_ff} + {1'b0, trim_len};
      trim_sum_next = trim_acc[POS_BITS] ? POS_MAX : trim_acc[POS_BITS-1:0];

      span_next = (span_count_ff >= SPAN_LIMIT) ? SPAN_LIMIT : span_count_ff + 1'b1;

      span_len = seg_to - tstart;
      empty    = (seg_to <= tstart);
      kept     = !empty && (span_len >= cfg.keep_min);
      drop_acc = {1'b0, drop_sum_ff} + {1'b0, span_len};

      kept_next     = kept_count_ff;
      drop_next     = drop_count_ff;
      drop_sum_next = drop_sum_ff;
      if (empty) begin
         outcome = OUT_EMPTY;
      end else if (kept) begin
         outcome   = OUT_KEPT;
         kept_next = (kept_count_ff >= SPAN_LIMIT) ? SPAN_LIMIT : kept_count_ff + 1'b1;
      end else begin
         outcome       = OUT_DROPPED;
         drop_next     = (drop_count_ff >= SPAN_LIMIT) ? SPAN_LIMIT : drop_count_ff + 1'b1;
         drop_sum_next = drop_acc[POS_BITS] ? POS_MAX : drop_acc[POS_BITS-1:0];
      end
   end

   always_comb begin
      result                 = '0;
      result.outcome         = outcome;
      result.seg_start       = tstart;
      result.seg_end         = seg_to;
      result.untrimmed_start = seg_from;
      result.span_number     = span_next;
      result.read_done       = item.is_end;
      if (item.is_end) begin
         result.spans_in_read = span_next;
         result.kept_total    = kept_next;
         result.dropped_total = drop_next;
         result.dropped_bases = drop_sum_next;
         result.trimmed_bases = trim_sum_next;
      end
   end

   always_comb begin
      last_cut_in   = last_cut_ff;
      span_count_in = span_count_ff;
      kept_count_in = kept_count_ff;
      drop_count_in = drop_count_ff;
      drop_sum_in   = drop_sum_ff;
      trim_sum_in   = trim_sum_ff;
      if (advance) begin
         if (item.is_end) begin
            last_cut_in   = '0;
            span_count_in = '0;
            kept_count_in = '0;
            drop_count_in = '0;
            drop_sum_in   = '0;
            trim_sum_in   = '0;
         end else begin
            last_cut_in   = seg_to;
            span_count_in = span_next;
            kept_count_in = kept_next;
            drop_count_in = drop_next;
            drop_sum_in   = drop_sum_next;
            trim_sum_in   = (span_count_ff == '0) ? trim_sum_ff : trim_sum_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_cut_ff   <= '0;
         span_count_ff <= '0;
         kept_count_ff <= '0;
         drop_count_ff <= '0;
         drop_sum_ff   <= '0;
         trim_sum_ff   <= '0;
      end else begin
         last_cut_ff   <= last_cut_in;
         span_count_ff <= span_count_in;
         kept_count_ff <= kept_count_in;
         drop_count_ff <= drop_count_in;
         drop_sum_ff   <= drop_sum_in;
         trim_sum_ff   <= trim_sum_in;
      end
   end

   a_span_max: assert property (@(posedge clock) disable iff (reset)
      span_count_ff <= SPAN_LIMIT)
      else $error("span count past limit");

   a_kept_le: assert property (@(posedge clock) disable iff (reset)
      kept_count_ff <= span_count_ff && drop_count_ff <= span_count_ff)
      else $error("kept or dropped count exceeds span count");

   a_end_clear: assert property (@(posedge clock) disable iff (reset)
      advance && item.is_end |=> span_count_ff == '0 && last_cut_ff == '0
                                 && trim_sum_ff == '0 && drop_sum_ff == '0)
      else $error("read state not cleared by end item");

   a_first_untrimmed: assert property (@(posedge clock) disable iff (reset)
      span_count_ff == '0 |-> tstart == seg_from)
      else $error("first span trimmed");

endmodule : rsc_span_eval
`default_nettype wire

/* hdl/rsc_out_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rsc_out_stage
// Result register; loads while empty or while its item is being taken.
// ----------------------------------------------------------------------------
module rsc_out_stage (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  load,
   input  rsc_pkg::result_type  result_in,
   input  wire                  out_ready,
   output logic                 up_ready,
   output logic                 out_valid,
   output rsc_pkg::result_type  result_out
);
   import rsc_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff, result_nx_in;

   assign up_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in     = load ? 1'b1 : ((valid_ff && out_ready) ? 1'b0 : valid_ff);
      result_nx_in = load ? result_in : result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_nx_in;
   end

   assign out_valid  = valid_ff;
   assign result_out = result_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> up_ready)
      else $error("result overwritten while stalled");

endmodule : rsc_out_stage
`default_nettype wire

/* hdl/read_span_cutter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// read_span_cutter
// Cuts a read into spans at enzyme cut positions and reports span outcomes
// and per-read totals, one result item per input item.
// ----------------------------------------------------------------------------
// Path: the input register holds an accepted item, span-eval computes its
// result, and the result register loads it and drives rsp_tvalid.
// Throughput: 1 item per cycle while rsp_tready is high; input and result
// registers decouple the sides; per-read state updates as each item advances.
// Reset: synchronous; clears config registers, read state and both valids.
// ----------------------------------------------------------------------------
module read_span_cutter (
   input  wire                              clock,
   input  wire                              reset,
   // config
   input  wire                              csr_wen,
   input  wire  [rsc_pkg::IDX_BITS-1:0]     csr_index,
   input  wire  [rsc_pkg::CFG_BITS-1:0]     csr_wdata,
   // input items
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [8*rsc_pkg::REQ_BYTES-1:0]  req_tdata,  // [19:0] position
   input  wire                              req_tlast,  // opcode: end of read
   // result items
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // [19:0] seg_start, [39:20] seg_end, [59:40] untrimmed_start,
   // [72:60] span_number, [85:73] spans_in_read, [98:86] kept_total,
   // [111:99] dropped_total, [131:112] dropped_bases, [151:132] trimmed_bases
   output logic [8*rsc_pkg::RSP_BYTES-1:0]  rsp_tdata,
   output logic [1:0]                       rsp_tuser,  // [1:0] outcome
   output logic                             rsp_tlast   // read_done
);
   import rsc_pkg::*;

   cfg_type    cfg;
   item_type   req_item, stage_item;
   result_type eval_result, rsp_result;
   logic       stage_valid, advance, out_up_ready;

   assign req_item.is_end   = req_tlast;
   assign req_item.position = req_tdata[POS_BITS-1:0];

   rsc_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rsc_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_item     (req_item),
      .down_ready  (out_up_ready),
      .stage_valid (stage_valid),
      .advance     (advance),
      .stage_item  (stage_item)
   );

   rsc_span_eval u_eval (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (stage_item),
      .cfg     (cfg),
      .result  (eval_result)
   );

   rsc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result_in  (eval_result),
      .out_ready  (rsp_tready),
      .up_ready   (out_up_ready),
      .out_valid  (rsp_tvalid),
      .result_out (rsp_result)
   );

   assign rsp_tuser = rsp_result.outcome;
   assign rsp_tlast = rsp_result.read_done;
   assign rsp_tdata = {rsp_result.trimmed_bases,
                       rsp_result.dropped_bases,
                       rsp_result.dropped_total,
                       rsp_result.kept_total,
                       rsp_result.spans_in_read,
                       rsp_result.span_number,
                       rsp_result.untrimmed_start,
                       rsp_result.seg_end,
                       rsp_result.seg_start};

   a_valid_path: assert property (@(posedge clock) disable iff (reset)
      advance |-> stage_valid)
      else $error("advance without a held item");

endmodule : read_span_cutter
`default_nettype wire

/* verif/read_span_cutter_tb.sv */
// ----------------------------------------------------------------------------
// read_span_cutter_tb
// Streams reads into the span cutter as site items closed by an end item,
// predicts every span report and the read totals in step with the accepted
// items, and checks each report field by field. Directed reads first, then
// a read that runs the dropped-base sum into saturation, then random reads
// under several register settings and stall patterns.
// ----------------------------------------------------------------------------
module read_span_cutter_tb;
   import rsc_pkg::*;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_wen = 1'b0;
   logic [IDX_BITS-1:0]         csr_index = '0;
   logic [CFG_BITS-1:0]         csr_wdata = '0;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [8*REQ_BYTES-1:0]      req_tdata = '0;  // [19:0] position
   logic                        req_tlast = 1'b0; // opcode: end of read
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   // [19:0] seg_start, [39:20] seg_end, [59:40] untrimmed_start,
   // [72:60] span_number, [85:73] spans_in_read, [98:86] kept_total,
   // [111:99] dropped_total, [131:112] dropped_bases, [151:132] trimmed_bases
   logic [8*RSP_BYTES-1:0]      rsp_tdata;
   logic [1:0]                  rsp_tuser;       // [1:0] outcome
   logic                        rsp_tlast;       // read_done

   read_span_cutter dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // register copies
   logic [5:0]          cut_shift_cfg = '0;
   logic [5:0]          remnant_cfg = '0;
   logic [POS_BITS-1:0] min_len_cfg = '0;

   // per-read state
   logic [POS_BITS-1:0] prev_cut = '0;
   logic [CNT_BITS-1:0] span_cnt = '0;
   logic [CNT_BITS-1:0] kept_cnt = '0;
   logic [CNT_BITS-1:0] drop_cnt = '0;
   logic [POS_BITS-1:0] drop_base_sum = '0;
   logic [POS_BITS-1:0] trim_base_sum = '0;

   item_type   read_items[$];
   result_type span_reports_due[$];
   int         items_queued = 0;
   int         bad_results = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   bit         item_taken = 1'b0;
   bit         send_now;
   result_type want, got, due_rep;

   function automatic logic [POS_BITS-1:0] pos_sat_add(input logic [POS_BITS-1:0] a,
                                                      input logic [POS_BITS-1:0] b);
      logic [POS_BITS:0] s;
      s = a + b;
      return (s > POS_MAX) ? POS_MAX : s[POS_BITS-1:0];
   endfunction

   function automatic logic [CNT_BITS-1:0] cnt_sat_inc(input logic [CNT_BITS-1:0] c);
      return (c >= SPAN_LIMIT) ? SPAN_LIMIT : c + 1'b1;
   endfunction

   // closes one span and returns its report; updates the per-read state
   function automatic result_type cut_span(input item_type it);
      result_type          r;
      logic [POS_BITS-1:0] from, cut_end, trimmed, t;
      from = prev_cut;
      cut_end = it.is_end ? it.position
                          : pos_sat_add(it.position, {{(POS_BITS-6){1'b0}}, cut_shift_cfg});
      trimmed = from;
      if (span_cnt != 0) begin
         t = pos_sat_add(from, {{(POS_BITS-6){1'b0}}, remnant_cfg});
         if (t > cut_end) t = cut_end;
         if (t < from) t = from;
         trim_base_sum = pos_sat_add(trim_base_sum, t - from);
         trimmed = t;
      end
      span_cnt = cnt_sat_inc(span_cnt);
      r = '0;
      if (cut_end <= trimmed) begin
         r.outcome = OUT_EMPTY;
      end else if (cut_end - trimmed >= min_len_cfg) begin
         r.outcome = OUT_KEPT;
         kept_cnt = cnt_sat_inc(kept_cnt);
      end else begin
         r.outcome = OUT_DROPPED;
         drop_cnt = cnt_sat_inc(drop_cnt);
         drop_base_sum = pos_sat_add(drop_base_sum, cut_end - trimmed);
      end
      r.seg_start = trimmed;
      r.seg_end = cut_end;
      r.untrimmed_start = from;
      r.span_number = span_cnt;
      r.read_done = it.is_end;
      if (it.is_end) begin
         r.spans_in_read = span_cnt;
         r.kept_total = kept_cnt;
         r.dropped_total = drop_cnt;
         r.dropped_bases = drop_base_sum;
         r.trimmed_bases = trim_base_sum;
         prev_cut = '0;
         span_cnt = '0;
         kept_cnt = '0;
         drop_cnt = '0;
         drop_base_sum = '0;
         trim_base_sum = '0;
      end else begin
         prev_cut = cut_end;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input longint unsigned exp_v,
                              input longint unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         bad_results++;
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (item_taken) read_items.pop_front();
         if (!(req_tvalid && !item_taken)) begin
            send_now = (read_items.size() != 0) && ($urandom_range(99) >= send_idle_pct);
            req_tvalid <= send_now;
            if (send_now) begin
               req_tdata <= {{(8*REQ_BYTES-POS_BITS){1'b0}}, read_items[0].position};
               req_tlast <= read_items[0].is_end;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // input accept and result monitor
   always @(posedge clock) begin
      item_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         due_rep = cut_span('{is_end: req_tlast, position: req_tdata[POS_BITS-1:0]});
         span_reports_due = {span_reports_due, due_rep};
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.outcome = outcome_type'(rsp_tuser);
         got.seg_start = rsp_tdata[19:0];
         got.seg_end = rsp_tdata[39:20];
         got.untrimmed_start = rsp_tdata[59:40];
         got.span_number = rsp_tdata[72:60];
         got.read_done = rsp_tlast;
         got.spans_in_read = rsp_tdata[85:73];
         got.kept_total = rsp_tdata[98:86];
         got.dropped_total = rsp_tdata[111:99];
         got.dropped_bases = rsp_tdata[131:112];
         got.trimmed_bases = rsp_tdata[151:132];
         if (span_reports_due.size() == 0) begin
            $error("result item with nothing expected");
            bad_results++;
         end else begin
            want = span_reports_due.pop_front();
            check_field("outcome", want.outcome, got.outcome);
            check_field("seg_start", want.seg_start, got.seg_start);
            check_field("seg_end", want.seg_end, got.seg_end);
            check_field("untrimmed_start", want.untrimmed_start, got.untrimmed_start);
            check_field("span_number", want.span_number, got.span_number);
            check_field("read_done", want.read_done, got.read_done);
            check_field("spans_in_read", want.spans_in_read, got.spans_in_read);
            check_field("kept_total", want.kept_total, got.kept_total);
            check_field("dropped_total", want.dropped_total, got.dropped_total);
            check_field("dropped_bases", want.dropped_bases, got.dropped_bases);
            check_field("trimmed_bases", want.trimmed_bases, got.trimmed_bases);
         end
      end
   end

   task automatic add_item(input logic is_end, input logic [POS_BITS-1:0] pos);
      item_type it;
      it.is_end = is_end;
      it.position = pos;
      read_items = {read_items, it};
      items_queued++;
   endtask

   task automatic drain();
      while (read_items.size() != 0 || span_reports_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CFG_BITS-1:0] val);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen <= 1'b0;
      case (idx)
         REG_CUT_SHIFT:   cut_shift_cfg = val[5:0];
         REG_REMNANT_LEN: remnant_cfg = val[5:0];
         REG_KEEP_MIN:    min_len_cfg = val[POS_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_cfg(input int cut, input int trim, input int min_len);
      write_reg(REG_CUT_SHIFT, CFG_BITS'(cut));
      write_reg(REG_REMNANT_LEN, CFG_BITS'(trim));
      write_reg(REG_KEEP_MIN, CFG_BITS'(min_len));
   endtask

   // sites mostly ascending, with some stray positions; wide reads span the range
   task automatic add_read();
      int                  n;
      bit                  wide;
      logic [POS_BITS-1:0] p;
      n = $urandom_range(0, 8);
      wide = ($urandom_range(4) == 0);
      p = '0;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0) p = POS_BITS'($urandom);
         else p = POS_BITS'(p + (wide ? $urandom_range(0, 200000) : $urandom_range(0, 120)));
         add_item(1'b0, p);
      end
      if ($urandom_range(9) == 0) p = POS_BITS'($urandom);
      else p = POS_BITS'(p + (wide ? $urandom_range(0, 100000) : $urandom_range(0, 150)));
      add_item(1'b1, p);
   endtask

   initial begin
      int mark;
      int pick;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: empty first span
      add_item(1'b1, 20'd0);
      add_item(1'b0, 20'd5);
      add_item(1'b1, 20'd7);
      drain();
      write_reg(REG_UNUSED, CFG_BITS'($urandom));

      set_cfg(4, 2, 8);
      // trim eats span, clamp at end, cut behind previous, cut saturation
      add_item(1'b0, 20'd10);
      add_item(1'b0, 20'd12);
      add_item(1'b0, 20'd100);
      add_item(1'b0, 20'd101);
      add_item(1'b0, 20'd103);
      add_item(1'b0, 20'd108);
      add_item(1'b0, 20'd3);
      add_item(1'b0, 20'hFFFFF);
      add_item(1'b1, 20'd50);
      add_item(1'b1, 20'd0);
      add_item(1'b0, 20'd2);
      add_item(1'b1, 20'hFFFFF);
      add_item(1'b0, 20'hFFFFC);
      add_item(1'b0, 20'hFFFFF);
      add_item(1'b1, 20'hFFFFF);
      drain();

      set_cfg(63, 63, 20'hFFFFF);
      add_item(1'b0, 20'hFFFFF);
      add_item(1'b0, 20'd0);
      add_item(1'b0, 20'h80000);
      add_item(1'b1, 20'hFFFFF);
      drain();

      // dropped bases run into saturation
      set_cfg(0, 0, 20'hFFFFF);
      for (int k = 0; k < 8; k++) add_item(1'b0, (k % 2 == 0) ? 20'd1000000 : 20'd0);
      add_item(1'b1, 20'd5);
      drain();

      for (int mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
         endcase
         for (int half = 0; half < 2; half++) begin
            pick = mode * 2 + half;
            if (pick == 0) set_cfg(0, 0, 0);
            else if (pick == 5) set_cfg(63, 63, 20'hFFFFF);
            else set_cfg($urandom_range(0, 63), $urandom_range(0, 63),
                         ($urandom_range(3) == 0) ? $urandom_range(0, 20'hFFFFF)
                                                  : $urandom_range(0, 300));
            mark = items_queued;
            while (items_queued - mark < 76) add_read();
            drain();
         end
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (10) @(posedge clock);
      if (bad_results == 0 && span_reports_due.size() == 0)
         $display("read_span_cutter_tb: done, clean");
      else
         $display("read_span_cutter_tb: done, errors");
      $finish;
   end

   initial begin
      #4000000;
      $display("read_span_cutter_tb: done, errors");
      $finish;
   end

endmodule

/* sim.f */
hdl/rsc_pkg.sv
hdl/rsc_cfg_regs.sv
hdl/rsc_in_stage.sv
hdl/rsc_span_eval.sv
hdl/rsc_out_stage.sv
hdl/read_span_cutter.sv
verif/read_span_cutter_tb.sv
